@@ src/trial_division_factorizer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the trial division factorizer
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_ASSERT_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define TDF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("trial_division_factorizer assertion failed");

// Checks that a condition implies a consequence in the following cycle.
`define TDF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("trial_division_factorizer assertion failed");

`else

`define TDF_ASSERT(label, clk, rst_n, prop)
`define TDF_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

@@ src/tdf_pkg.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer package
// Shared widths, the sequencer state type and the divider result bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  localparam logic [VALUE_BITS-1:0] FACTOR_TWO   = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] FIRST_ODD    = VALUE_BITS'(3);
  localparam logic [VALUE_BITS-1:0] ODD_STEP     = VALUE_BITS'(2);

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_TWOS,
    S_DIV_START,
    S_DIV_WAIT,
    S_DECIDE,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    value_t quot;
    value_t rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ src/tdf_div.sv @@
// ---------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ---------------------------------------------------------------------------
`default_nettype none

module tdf_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire tdf_pkg::value_t  dividend,
  input  wire tdf_pkg::value_t  divisor,
  output tdf_pkg::div_res_t     res
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tdf_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  tdf_pkg::value_t               quo_r, quo_nxt;
  tdf_pkg::value_t               rem_r, rem_nxt;
  tdf_pkg::value_t               dvs_r, dvs_nxt;
  logic [tdf_pkg::VALUE_BITS:0]  shifted;
  logic [tdf_pkg::VALUE_BITS:0]  diff;
  logic                          ge;

  always_comb begin
    shifted  = {rem_r, quo_r[tdf_pkg::VALUE_BITS-1]};
    ge       = shifted >= {1'b0, dvs_r};
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tdf_pkg::CNT_BITS'(tdf_pkg::VALUE_BITS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[tdf_pkg::VALUE_BITS-1:0] : shifted[tdf_pkg::VALUE_BITS-1:0];
      quo_nxt = {quo_r[tdf_pkg::VALUE_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tdf_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

@@ src/trial_division_factorizer.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factors of one input value in ascending order, repeats
// included, one factor per output transfer; the final factor carries last.
//
// The input channel takes one value per transfer and stalls until every
// factor of that value has been handed to the output register. Inputs of
// zero or one give a single transfer with factor zero, last and empty_res.
// Every odd trial divisor costs one pass of the shared restoring
// divider, whether it divides or not; the divisor loop runs until the
// divisor exceeds the quotient. A large prime near 2^31 therefore needs
// about 23170 passes. A held output stall freezes the sequencer at its
// next emission and the pending factor stays on the output ports.
// Synchronous reset returns the sequencer to idle and drops the output
// valid; no value is retained.
// ---------------------------------------------------------------------------
`default_nettype none

`include "trial_division_factorizer_assert.svh"

module trial_division_factorizer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire tdf_pkg::value_t  in_value,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      tdf_pkg::value_t  out_factor,
  output      logic             out_last,
  output      logic             out_empty_res
);

  tdf_pkg::state_t   state_r, state_nxt;
  tdf_pkg::value_t   rem_r, rem_nxt;
  tdf_pkg::value_t   div_r, div_nxt;
  logic              out_valid_r, out_valid_nxt;
  tdf_pkg::value_t   out_factor_r, out_factor_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_res_r, out_empty_res_nxt;
  logic              can_emit;
  logic              emit;
  logic              div_start;
  tdf_pkg::div_res_t div_res;

  tdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (div_r),
    .res      (div_res)
  );

  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt         = state_r;
    rem_nxt           = rem_r;
    div_nxt           = div_r;
    emit              = 1'b0;
    div_start         = 1'b0;
    out_factor_nxt    = out_factor_r;
    out_last_nxt      = out_last_r;
    out_empty_res_nxt = out_empty_res_r;
    case (state_r)
      tdf_pkg::S_IDLE: begin
        if (in_valid) begin
          rem_nxt   = in_value;
          state_nxt = (in_value < tdf_pkg::FACTOR_TWO) ? tdf_pkg::S_EMPTY : tdf_pkg::S_TWOS;
        end
      end
      tdf_pkg::S_EMPTY: begin
        if (can_emit) begin
          emit              = 1'b1;
          out_factor_nxt    = '0;
          out_last_nxt      = 1'b1;
          out_empty_res_nxt = 1'b1;
          state_nxt         = tdf_pkg::S_IDLE;
        end
      end
      tdf_pkg::S_TWOS: begin
        if (!rem_r[0]) begin
          if (can_emit) begin
            emit              = 1'b1;
            out_factor_nxt    = tdf_pkg::FACTOR_TWO;
            out_last_nxt      = rem_r == tdf_pkg::FACTOR_TWO;
            out_empty_res_nxt = 1'b0;
            rem_nxt           = rem_r >> 1;
            if (rem_r == tdf_pkg::FACTOR_TWO) begin
              state_nxt = tdf_pkg::S_IDLE;
            end
          end
        end else begin
          div_nxt   = tdf_pkg::FIRST_ODD;
          state_nxt = tdf_pkg::S_DIV_START;
        end
      end
      tdf_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = tdf_pkg::S_DIV_WAIT;
      end
      tdf_pkg::S_DIV_WAIT: begin
        if (div_res.done) begin
          state_nxt = tdf_pkg::S_DECIDE;
        end
      end
      tdf_pkg::S_DECIDE: begin
        if (div_r > div_res.quot) begin
          state_nxt = tdf_pkg::S_FINAL;
        end else if (div_res.rem == '0) begin
          if (can_emit) begin
            emit              = 1'b1;
            out_factor_nxt    = div_r;
            out_last_nxt      = 1'b0;
            out_empty_res_nxt = 1'b0;
            rem_nxt           = div_res.quot;
            state_nxt         = tdf_pkg::S_DIV_START;
          end
        end else begin
          div_nxt   = div_r + tdf_pkg::ODD_STEP;
          state_nxt = tdf_pkg::S_DIV_START;
        end
      end
      tdf_pkg::S_FINAL: begin
        if (can_emit) begin
          emit              = 1'b1;
          out_factor_nxt    = rem_r;
          out_last_nxt      = 1'b1;
          out_empty_res_nxt = 1'b0;
          state_nxt         = tdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tdf_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r           <= rem_nxt;
    div_r           <= div_nxt;
    out_factor_r    <= out_factor_nxt;
    out_last_r      <= out_last_nxt;
    out_empty_res_r <= out_empty_res_nxt;
  end

  assign in_stall      = state_r != tdf_pkg::S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_factor    = out_factor_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_res_r;

  `TDF_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, state_r != tdf_pkg::S_IDLE)
  `TDF_ASSERT(a_start_when_free, clk, rst_n, !div_start || !div_res.busy)
  `TDF_ASSERT(a_divisor_factor_exact, clk, rst_n, !(emit && state_r == tdf_pkg::S_DECIDE) || div_res.rem == '0)
  `TDF_ASSERT(a_empty_is_last, clk, rst_n, !(out_valid && out_empty_res) || (out_last && out_factor == '0))

endmodule

`default_nettype wire
